FILE: design/afrc_pkg.sv
package afrc_pkg;

    localparam logic [7:0]  START_DELIM     = 8'h7E;
    localparam logic [7:0]  CSUM_BASE       = 8'hFF;
    localparam logic [15:0] MAX_LEN_DEFAULT = 16'd256;

    typedef enum logic [1:0] {
        ST_DATA     = 2'd0,
        ST_CSUM_OK  = 2'd1,
        ST_CSUM_BAD = 2'd2,
        ST_LEN_REJ  = 2'd3
    } status_t;

    typedef struct packed {
        logic       valid;
        logic [7:0] data;
        logic       first;
        logic       last;
        status_t    status;
    } result_t;

endpackage

FILE: design/afrc_parser.sv
module afrc_parser (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic [15:0]        cfg_wr_data,
    input  logic               advance,
    input  logic [7:0]         rx_data,
    output afrc_pkg::result_t  result
);

    typedef enum logic [2:0] {
        PH_HUNT   = 3'd0,
        PH_LEN_HI = 3'd1,
        PH_LEN_LO = 3'd2,
        PH_DATA   = 3'd3,
        PH_CSUM   = 3'd4
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [7:0]  len_hi_reg, len_hi_next;
    logic [15:0] remaining_reg, remaining_next;
    logic [7:0]  sum_reg, sum_next;
    logic        first_pending_reg, first_pending_next;
    logic [15:0] max_len_reg;

    logic [15:0] frame_len;
    logic [15:0] remaining_dec;
    logic [7:0]  csum_expect;

    assign frame_len     = {len_hi_reg, rx_data};
    assign remaining_dec = remaining_reg - 16'd1;
    assign csum_expect   = afrc_pkg::CSUM_BASE - sum_reg;

    always_comb
    begin
        phase_next         = phase_reg;
        len_hi_next        = len_hi_reg;
        remaining_next     = remaining_reg;
        sum_next           = sum_reg;
        first_pending_next = first_pending_reg;
        result             = '0;
        result.status      = afrc_pkg::ST_DATA;

        case (phase_reg)
            PH_LEN_HI:
            begin
                len_hi_next = rx_data;
                phase_next  = PH_LEN_LO;
            end
            PH_LEN_LO:
            begin
                if (frame_len == 16'd0 || frame_len > max_len_reg)
                begin
                    phase_next    = PH_HUNT;
                    result.valid  = 1'b1;
                    result.last   = 1'b1;
                    result.status = afrc_pkg::ST_LEN_REJ;
                end
                else
                begin
                    remaining_next     = frame_len;
                    sum_next           = 8'd0;
                    first_pending_next = 1'b1;
                    phase_next         = PH_DATA;
                end
            end
            PH_DATA:
            begin
                result.valid       = 1'b1;
                result.data        = rx_data;
                result.first       = first_pending_reg;
                first_pending_next = 1'b0;
                sum_next           = sum_reg + rx_data;
                remaining_next     = remaining_dec;
                if (remaining_dec == 16'd0)
                begin
                    phase_next = PH_CSUM;
                end
            end
            PH_CSUM:
            begin
                result.valid  = 1'b1;
                result.data   = rx_data;
                result.last   = 1'b1;
                result.status = (csum_expect == rx_data) ? afrc_pkg::ST_CSUM_OK
                                                         : afrc_pkg::ST_CSUM_BAD;
                phase_next    = PH_HUNT;
            end
            default:
            begin
                // hunt: drop everything but the start delimiter
                phase_next = (rx_data == afrc_pkg::START_DELIM) ? PH_LEN_HI : PH_HUNT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= PH_HUNT;
            len_hi_reg        <= 8'd0;
            remaining_reg     <= 16'd0;
            sum_reg           <= 8'd0;
            first_pending_reg <= 1'b0;
            max_len_reg       <= afrc_pkg::MAX_LEN_DEFAULT;
        end
        else
        begin
            if (advance)
            begin
                phase_reg         <= phase_next;
                len_hi_reg        <= len_hi_next;
                remaining_reg     <= remaining_next;
                sum_reg           <= sum_next;
                first_pending_reg <= first_pending_next;
            end
            if (cfg_wr_en)
            begin
                max_len_reg <= cfg_wr_data;
            end
        end
    end

endmodule

FILE: design/api_frame_receiver_checksum_top.sv
// Frame receiver: takes one serial byte per request on the input channel
// (in_valid / in_stall / rx_byte), hunts for the start delimiter, reads a
// 16-bit big-endian length and passes the frame-data bytes on the output
// channel (out_valid / out_stall / out_byte, first_flag, last_flag, status).
// The byte after the data gives an end request with the checksum verdict;
// a zero or oversized length gives one rejection request instead.
// The largest accepted length (256 after reset) is written through
// cfg_wr_en / cfg_wr_data; the user must write it only while the block is
// idle, as the block does not enforce this. A byte accepted into the input
// register is decoded by the parser and its request is then captured in
// the output register. Throughput: one byte per cycle, unless a byte's
// request meets a full output register held by out_stall.
// Bytes that give no output request (delimiter, length, hunted noise)
// never wait on the output side.
// When the receiver stalls, the output register holds its request and the
// input register holds one byte; in_stall rises only when that byte would
// produce a request the full output register cannot take.
// Reset clears both registers, the parser back to hunting and the maximum
// length to 256.
module api_frame_receiver_checksum_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  out_byte,
    output logic        first_flag,
    output logic        last_flag,
    output logic [1:0]  status
);

    logic               in_valid_reg;
    logic [7:0]         in_byte_reg;
    logic               out_valid_reg;
    logic [7:0]         out_byte_reg;
    logic               out_first_reg;
    logic               out_last_reg;
    afrc_pkg::status_t  out_status_reg;

    afrc_pkg::result_t  result;
    logic               out_free;
    logic               advance;
    logic               in_take;

    assign out_free = !out_valid_reg || !out_stall;
    assign advance  = in_valid_reg && (!result.valid || out_free);
    assign in_stall = in_valid_reg && !advance;
    assign in_take  = in_valid && !in_stall;

    afrc_parser u_parser (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .advance     (advance),
        .rx_data     (in_byte_reg),
        .result      (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_take)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end

            if (advance && result.valid)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_byte_reg <= rx_byte;
        end
        if (advance && result.valid)
        begin
            out_byte_reg   <= result.data;
            out_first_reg  <= result.first;
            out_last_reg   <= result.last;
            out_status_reg <= result.status;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_byte   = out_byte_reg;
    assign first_flag = out_first_reg;
    assign last_flag  = out_last_reg;
    assign status     = out_status_reg;

endmodule

FILE: test/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    typedef enum logic [2:0] {
        HUNT,
        LEN_HI,
        LEN_LO,
        FRAME_DATA,
        CHECKSUM
    } parse_phase_t;

    typedef struct packed {
        logic [7:0]        data;
        logic              first;
        logic              last;
        afrc_pkg::status_t status;
    } frame_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [15:0] cfg_wr_data = 16'd0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  rx_byte = 8'd0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [7:0]  out_byte;
    logic        first_flag;
    logic        last_flag;
    logic [1:0]  status;

    // receiver state as the block should hold it
    parse_phase_t parse_phase = HUNT;
    logic [15:0]  max_length = afrc_pkg::MAX_LEN_DEFAULT;
    logic [7:0]   length_high;
    logic [15:0]  data_left;
    logic [7:0]   data_sum;
    logic         type_pending;

    logic [7:0]    rx_pending[$];
    logic [7:0]    frame_body[$];
    frame_result_t predicted_results[$];
    int            queued_bytes = 0;
    int            mismatch_count = 0;

    int sender_burst = 0;
    int sender_gap = 0;
    int stall_mode = 0;
    int stall_run = 0;

    api_frame_receiver_checksum_top u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .rx_byte     (rx_byte),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_byte    (out_byte),
        .first_flag  (first_flag),
        .last_flag   (last_flag),
        .status      (status)
    );

    always #4 clk = ~clk;

    task automatic parse_rx_byte(input logic [7:0] b);
        frame_result_t r;
        logic [15:0]   len;
        logic [7:0]    want_sum;
        case (parse_phase)
            LEN_HI:
            begin
                length_high = b;
                parse_phase = LEN_LO;
            end
            LEN_LO:
            begin
                len = {length_high, b};
                if (len == 16'd0 || len > max_length)
                begin
                    r = '{data: 8'd0, first: 1'b0, last: 1'b1,
                          status: afrc_pkg::ST_LEN_REJ};
                    predicted_results.push_back(r);
                    parse_phase = HUNT;
                end
                else
                begin
                    data_left = len;
                    data_sum = 8'd0;
                    type_pending = 1'b1;
                    parse_phase = FRAME_DATA;
                end
            end
            FRAME_DATA:
            begin
                r = '{data: b, first: type_pending, last: 1'b0, status: afrc_pkg::ST_DATA};
                predicted_results.push_back(r);
                type_pending = 1'b0;
                data_sum = data_sum + b;
                data_left = data_left - 16'd1;
                if (data_left == 16'd0)
                    parse_phase = CHECKSUM;
            end
            CHECKSUM:
            begin
                want_sum = afrc_pkg::CSUM_BASE - data_sum;
                r = '{data: b, first: 1'b0, last: 1'b1,
                      status: (want_sum == b) ? afrc_pkg::ST_CSUM_OK
                                              : afrc_pkg::ST_CSUM_BAD};
                predicted_results.push_back(r);
                parse_phase = HUNT;
            end
            default:
                parse_phase = (b == afrc_pkg::START_DELIM) ? LEN_HI : HUNT;
        endcase
    endtask

    // driver: present bytes in bursts, hold a stalled request unchanged
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                parse_rx_byte(rx_byte);
                void'(rx_pending.pop_front());
            end
            if (in_valid && in_stall)
            begin
            end
            else if (sender_gap != 0)
            begin
                sender_gap--;
                in_valid <= 1'b0;
            end
            else if (rx_pending.size() != 0)
            begin
                in_valid <= 1'b1;
                rx_byte <= rx_pending[0];
                if (sender_burst > 0)
                    sender_burst--;
                if (sender_burst == 0)
                begin
                    sender_burst = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                               : $urandom_range(1, 16);
                    sender_gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end
            end
            else
                in_valid <= 1'b0;
        end
    end

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want)
        begin
            $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    // monitor: compare each accepted result, then pick the next stall
    always @(posedge clk)
    begin
        frame_result_t want;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (predicted_results.size() == 0)
                begin
                    $display("%0t: result with none expected: out_byte %0h status %0d",
                             $time, out_byte, status);
                    mismatch_count++;
                end
                else
                begin
                    want = predicted_results.pop_front();
                    check_field("out_byte", want.data, out_byte);
                    check_field("first_flag", 8'(want.first), 8'(first_flag));
                    check_field("last_flag", 8'(want.last), 8'(last_flag));
                    check_field("status", 8'(want.status), 8'(status));
                end
            end
            if (stall_run == 0)
            begin
                stall_mode = $urandom_range(0, 3);
                stall_run = $urandom_range(20, 200);
            end
            stall_run--;
            case (stall_mode)
                1: out_stall <= ($urandom_range(0, 9) < 3);
                2: out_stall <= ($urandom_range(0, 3) != 0);
                3: out_stall <= ~out_stall;
                default: out_stall <= 1'b0;
            endcase
        end
    end

    task automatic queue_rx_byte(input logic [7:0] b);
        rx_pending.push_back(b);
        queued_bytes++;
    endtask

    task automatic queue_header(input logic [15:0] len);
        queue_rx_byte(afrc_pkg::START_DELIM);
        queue_rx_byte(len[15:8]);
        queue_rx_byte(len[7:0]);
    endtask

    // send frame_body with a checksum, corrupted on request
    task automatic queue_frame(input bit bad_sum);
        logic [7:0] sum;
        logic [7:0] csum;
        sum = 8'd0;
        queue_header(16'(frame_body.size()));
        foreach (frame_body[i])
        begin
            queue_rx_byte(frame_body[i]);
            sum = sum + frame_body[i];
        end
        csum = afrc_pkg::CSUM_BASE - sum;
        if (bad_sum)
            csum = csum ^ 8'($urandom_range(1, 255));
        queue_rx_byte(csum);
    endtask

    task automatic fill_body(input int len);
        frame_body.delete();
        repeat (len)
            frame_body.push_back(8'($urandom_range(0, 255)));
    endtask

    task automatic queue_rejected_length();
        logic [15:0] len;
        if (max_length == 16'hFFFF || $urandom_range(0, 3) == 0)
            len = 16'd0;
        else
            len = 16'($urandom_range(int'(max_length) + 1, 65535));
        queue_header(len);
    endtask

    task automatic queue_random_traffic(input int n_bytes);
        int          goal;
        int          kind;
        int          cap;
        int          len;
        logic [7:0]  b;
        goal = queued_bytes + n_bytes;
        while (queued_bytes < goal)
        begin
            kind = $urandom_range(0, 99);
            cap = (max_length < 16'd24) ? int'(max_length) : 24;
            if ($urandom_range(0, 9) == 0)
                cap = (max_length < 16'd300) ? int'(max_length) : 300;
            if (kind < 65 && cap > 0)
            begin
                fill_body($urandom_range(1, cap));
                queue_frame($urandom_range(0, 4) == 0);
            end
            else if (kind < 80 || cap == 0)
                queue_rejected_length();
            else if (kind < 90)
            begin
                repeat ($urandom_range(1, 4))
                begin
                    b = 8'($urandom_range(0, 255));
                    if (b == afrc_pkg::START_DELIM)
                        b = b ^ 8'h01;
                    queue_rx_byte(b);
                end
            end
            else
            begin
                // truncated frame: the following bytes are taken as its data
                len = $urandom_range(1, cap);
                queue_header(16'(len));
                repeat ($urandom_range(0, len - 1))
                    queue_rx_byte(8'($urandom_range(0, 255)));
            end
        end
    endtask

    task automatic wait_idle();
        while (rx_pending.size() != 0 || in_valid || predicted_results.size() != 0)
            @(negedge clk);
        repeat (8) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_max_length(input logic [15:0] value);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        max_length = value;
        @(negedge clk);
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // noise while hunting, then length boundaries at the reset maximum
        queue_rx_byte(8'h00);
        queue_rx_byte(8'hFF);
        queue_header(16'd0);
        queue_header(16'hFFFF);
        queue_header(afrc_pkg::MAX_LEN_DEFAULT + 16'd1);
        // checksum byte equal to the delimiter
        frame_body = {8'h81};
        queue_frame(1'b0);
        // delimiter value inside the data, bad checksum
        frame_body = {8'hFF, afrc_pkg::START_DELIM, 8'h80};
        queue_frame(1'b1);
        queue_random_traffic(150);
        wait_idle();

        write_max_length(16'd1);
        frame_body = {8'h3C};
        queue_frame(1'b0);
        queue_header(16'd2);
        queue_random_traffic(100);
        wait_idle();

        // every length is rejected
        write_max_length(16'd0);
        queue_header(16'd1);
        queue_random_traffic(40);
        wait_idle();

        write_max_length(16'hFFFF);
        fill_body(300);
        queue_frame(1'b0);
        queue_header(16'd0);
        queue_random_traffic(80);
        wait_idle();

        write_max_length(16'($urandom_range(2, 300)));
        queue_random_traffic(100);
        wait_idle();

        if (mismatch_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule

FILE: sim.f
design/afrc_pkg.sv
design/afrc_parser.sv
design/api_frame_receiver_checksum_top.sv
test/tb.sv
